### hw/rtl/cbc_pkg.sv
// Package for the color box centroid tracker: widths, register indexes,
// payload structs and the internal control structs. No dependencies.
`timescale 1ns / 1ps

package cbc_pkg;

  localparam int FRAME_SIDE   = 128;
  localparam int CHANNEL_BITS = 5;

  localparam int CoordW = 7;
  localparam int CntW   = 15;
  localparam int SumW   = 21;
  localparam int BoundW = 6;
  localparam int RegIdxW = 3;
  localparam int DivCntW = $clog2(SumW);

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [CoordW-1:0] CentLim =
      CoordW'((FRAME_SIDE - 1 < 127) ? FRAME_SIDE - 1 : 127);

  // configuration register indexes
  localparam logic [RegIdxW-1:0] RegDarkLower = 3'd0;
  localparam logic [RegIdxW-1:0] RegDarkUpper = 3'd1;
  localparam logic [RegIdxW-1:0] RegRedRLower = 3'd2;
  localparam logic [RegIdxW-1:0] RegRedRUpper = 3'd3;
  localparam logic [RegIdxW-1:0] RegRedGLower = 3'd4;
  localparam logic [RegIdxW-1:0] RegRedGUpper = 3'd5;
  localparam logic [RegIdxW-1:0] RegRedBLower = 3'd6;
  localparam logic [RegIdxW-1:0] RegRedBUpper = 3'd7;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] pix_red;
    logic [CHANNEL_BITS-1:0] pix_green;
    logic [CHANNEL_BITS-1:0] pix_blue;
    logic [CoordW-1:0]       col_pos;
    logic [CoordW-1:0]       row_pos;
    logic                    frame_end;
  } pix_t;

  typedef struct packed {
    logic [CntW-1:0]   dark_hits;
    logic [CoordW-1:0] dark_cx;
    logic [CoordW-1:0] dark_cy;
    logic              dark_found;
    logic [CntW-1:0]   red_hits;
    logic [CoordW-1:0] red_cx;
    logic [CoordW-1:0] red_cy;
    logic              red_found;
  } res_t;

  typedef struct packed {
    logic [BoundW-1:0] dark_lower;
    logic [BoundW-1:0] dark_upper;
    logic [BoundW-1:0] red_r_lower;
    logic [BoundW-1:0] red_r_upper;
    logic [BoundW-1:0] red_g_lower;
    logic [BoundW-1:0] red_g_upper;
    logic [BoundW-1:0] red_b_lower;
    logic [BoundW-1:0] red_b_upper;
  } cfg_t;

  typedef struct packed {
    logic [CntW-1:0] dark_count;
    logic [SumW-1:0] dark_sum_x;
    logic [SumW-1:0] dark_sum_y;
    logic [CntW-1:0] red_count;
    logic [SumW-1:0] red_sum_x;
    logic [SumW-1:0] red_sum_y;
  } acc_t;

  typedef struct packed {
    logic            start;
    logic [SumW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [SumW-1:0] quotient;
  } div_rsp_t;

endpackage

### hw/rtl/cbc_accum.sv
// Box test and per-box hit count and coordinate sums, saturating.
// Depends on cbc_pkg.
`timescale 1ns / 1ps

module cbc_accum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cbc_pkg::cfg_t cfg_i,
  input  logic        en_i,
  input  logic        clear_i,
  input  cbc_pkg::pix_t pix_i,
  output cbc_pkg::acc_t acc_o
);
  import cbc_pkg::*;

  acc_t acc_q, acc_d;

  function automatic logic in_range(input logic [CHANNEL_BITS-1:0] v,
                                    input logic [BoundW-1:0] lo,
                                    input logic [BoundW-1:0] hi);
    logic [BoundW-1:0] vx;
    vx = BoundW'(v);
    return (vx > lo) && (vx < hi);
  endfunction

  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] s,
                                              input logic [CoordW-1:0] c);
    logic [SumW:0] t;
    t = {1'b0, s} + (SumW+1)'(c);
    return t[SumW] ? SumMax : t[SumW-1:0];
  endfunction

  logic dark_hit, red_hit;

  always_comb begin
    dark_hit = in_range(pix_i.pix_red, cfg_i.dark_lower, cfg_i.dark_upper) &&
               in_range(pix_i.pix_green, cfg_i.dark_lower, cfg_i.dark_upper) &&
               in_range(pix_i.pix_blue, cfg_i.dark_lower, cfg_i.dark_upper);
    red_hit  = in_range(pix_i.pix_red, cfg_i.red_r_lower, cfg_i.red_r_upper) &&
               in_range(pix_i.pix_green, cfg_i.red_g_lower, cfg_i.red_g_upper) &&
               in_range(pix_i.pix_blue, cfg_i.red_b_lower, cfg_i.red_b_upper);
    acc_d = acc_q;
    if (clear_i) begin
      acc_d = '0;
    end else if (en_i) begin
      // a full count drops the pixel entirely
      if (dark_hit && acc_q.dark_count != CntMax) begin
        acc_d.dark_count = acc_q.dark_count + 1'b1;
        acc_d.dark_sum_x = sat_add(acc_q.dark_sum_x, pix_i.col_pos);
        acc_d.dark_sum_y = sat_add(acc_q.dark_sum_y, pix_i.row_pos);
      end
      if (red_hit && acc_q.red_count != CntMax) begin
        acc_d.red_count = acc_q.red_count + 1'b1;
        acc_d.red_sum_x = sat_add(acc_q.red_sum_x, pix_i.col_pos);
        acc_d.red_sum_y = sat_add(acc_q.red_sum_y, pix_i.row_pos);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

### hw/rtl/cbc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on cbc_pkg.
`timescale 1ns / 1ps

module cbc_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cbc_pkg::div_req_t req_i,
  output cbc_pkg::div_rsp_t rsp_o
);
  import cbc_pkg::*;

  logic [SumW-1:0]    quo_q, quo_d;
  logic [CntW-1:0]    rem_q, rem_d;
  logic [CntW-1:0]    dvs_q, dvs_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntW:0]      trial;
  logic [CntW:0]      diff;

  always_comb begin
    trial  = {rem_q, quo_q[SumW-1]};
    diff   = trial - {1'b0, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[CntW-1:0];
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = trial[CntW-1:0];
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = DivCntW'(SumW - 1);
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### hw/rtl/color_box_centroid_tracker.sv
// Top level of the color box centroid tracker: config registers, the
// frame-end sequencer and the result register. Uses cbc_pkg, cbc_accum, cbc_div.
`timescale 1ns / 1ps

// Usage:
// Pixel items enter on in_valid_i/in_ready_o with in_data_i (RGB, column,
// row, frame_end). A plain pixel is tested against both boxes and added to
// the box sums in the cycle it is accepted; the block is ready again at once,
// so plain pixels stream at one item per cycle.
// The item marked frame_end makes one result item on out_valid_o/out_ready_i.
// Its four centroids are worked out one after another on a single shared
// restoring divider (each: a start state, the quotient bits at one per cycle
// and a store), and the result is loaded into the output register after the
// last one; in_ready_o stays low from the acceptance of the frame_end item
// until that load. Then the box sums are cleared.
// The result sits in an output register: pixels keep being accepted while
// it waits. If the next frame_end finishes its divisions while the previous
// result is still not taken, the block holds, not ready, until it is.
// Configuration is to be written through cfg_we_i/cfg_idx_i/cfg_data_i
// only while idle; the block itself does not enforce this. Reset restores
// the register defaults, clears the sums and the output valid.
module color_box_centroid_tracker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  cbc_pkg::pix_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output cbc_pkg::res_t              out_data_o,
  input  logic                       cfg_we_i,
  input  logic [cbc_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [cbc_pkg::BoundW-1:0]  cfg_data_i
);
  import cbc_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StStart = 2'd1;
  localparam logic [1:0] StWait  = 2'd2;
  localparam logic [1:0] StOut   = 2'd3;

  localparam logic [1:0] OpDarkX = 2'd0;
  localparam logic [1:0] OpDarkY = 2'd1;
  localparam logic [1:0] OpRedX  = 2'd2;
  localparam logic [1:0] OpRedY  = 2'd3;

  cfg_t cfg_q;
  acc_t acc;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [1:0] state_q, state_d;
  logic [1:0] op_q, op_d;
  logic [CoordW-1:0] cent_q [4];
  logic [CoordW-1:0] cent_val;
  logic [CntW-1:0]   op_count;
  logic accept, load, out_valid_q;
  res_t out_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dark_lower  <= 6'd0;
      cfg_q.dark_upper  <= 6'd4;
      cfg_q.red_r_lower <= 6'd28;
      cfg_q.red_r_upper <= 6'd32;
      cfg_q.red_g_lower <= 6'd0;
      cfg_q.red_g_upper <= 6'd4;
      cfg_q.red_b_lower <= 6'd0;
      cfg_q.red_b_upper <= 6'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDarkLower: cfg_q.dark_lower  <= cfg_data_i;
        RegDarkUpper: cfg_q.dark_upper  <= cfg_data_i;
        RegRedRLower: cfg_q.red_r_lower <= cfg_data_i;
        RegRedRUpper: cfg_q.red_r_upper <= cfg_data_i;
        RegRedGLower: cfg_q.red_g_lower <= cfg_data_i;
        RegRedGUpper: cfg_q.red_g_upper <= cfg_data_i;
        RegRedBLower: cfg_q.red_b_lower <= cfg_data_i;
        RegRedBUpper: cfg_q.red_b_upper <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign load       = (state_q == StOut) && (!out_valid_q || out_ready_i);

  cbc_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .en_i    (accept),
    .clear_i (load),
    .pix_i   (in_data_i),
    .acc_o   (acc)
  );

  // operand select for the shared divider
  always_comb begin
    div_req.start = (state_q == StStart);
    case (op_q)
      OpDarkX: begin
        div_req.dividend = acc.dark_sum_x;
        op_count         = acc.dark_count;
      end
      OpDarkY: begin
        div_req.dividend = acc.dark_sum_y;
        op_count         = acc.dark_count;
      end
      OpRedX: begin
        div_req.dividend = acc.red_sum_x;
        op_count         = acc.red_count;
      end
      default: begin
        div_req.dividend = acc.red_sum_y;
        op_count         = acc.red_count;
      end
    endcase
    div_req.divisor = op_count;
  end

  cbc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // empty box gives 0, clamp to the frame edge
  always_comb begin
    if (op_count == '0) begin
      cent_val = '0;
    end else if (div_rsp.quotient > SumW'(CentLim)) begin
      cent_val = CentLim;
    end else begin
      cent_val = div_rsp.quotient[CoordW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      StIdle: begin
        if (accept && in_data_i.frame_end) begin
          state_d = StStart;
          op_d    = OpDarkX;
        end
      end
      StStart: state_d = StWait;
      StWait: begin
        if (div_rsp.done) begin
          if (op_q == OpRedY) begin
            state_d = StOut;
          end else begin
            op_d    = op_q + 1'b1;
            state_d = StStart;
          end
        end
      end
      StOut: begin
        if (load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      op_q        <= OpDarkX;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StWait && div_rsp.done) begin
      cent_q[op_q] <= cent_val;
    end
    if (load) begin
      out_q.dark_hits  <= acc.dark_count;
      out_q.dark_cx    <= cent_q[OpDarkX];
      out_q.dark_cy    <= cent_q[OpDarkY];
      out_q.dark_found <= (acc.dark_count != '0);
      out_q.red_hits   <= acc.red_count;
      out_q.red_cx     <= cent_q[OpRedX];
      out_q.red_cy     <= cent_q[OpRedY];
      out_q.red_found  <= (acc.red_count != '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### tb/sv/color_box_centroid_tracker_tb.sv
// Self-checking bench for the color box centroid tracker: directed pixel table, then
// random frames under several box settings. Uses cbc_pkg and color_box_centroid_tracker.
`timescale 1ns / 1ps

module color_box_centroid_tracker_tb;
  import cbc_pkg::*;

  localparam int CycleLimit  = 600000;
  localparam int SettleCycles = 120;
  localparam int ItemsPerSetting = 117;
  localparam int LongFrame = 33000;

  localparam cfg_t RstBounds = '{dark_lower: 6'd0, dark_upper: 6'd4,
                                 red_r_lower: 6'd28, red_r_upper: 6'd32,
                                 red_g_lower: 6'd0, red_g_upper: 6'd4,
                                 red_b_lower: 6'd0, red_b_upper: 6'd4};

  typedef struct {
    pix_t pix;
    int   reps;
    bit   typed;
    res_t want;
  } pix_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pix_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_data;
  logic cfg_we = 1'b0;
  logic [RegIdxW-1:0] cfg_idx = RegDarkLower;
  logic [BoundW-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  // predictor state
  cfg_t bounds = RstBounds;
  acc_t tally = '0;
  res_t frame_summaries_q[$];
  res_t seen_want;

  color_box_centroid_tracker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  function automatic bit in_span(input logic [BoundW-1:0] v, input logic [BoundW-1:0] lo,
                                 input logic [BoundW-1:0] hi);
    return (v > lo) && (v < hi);
  endfunction

  function automatic void add_hit(inout logic [CntW-1:0] cnt, inout logic [SumW-1:0] sx,
                                  inout logic [SumW-1:0] sy, input logic [CoordW-1:0] x,
                                  input logic [CoordW-1:0] y);
    logic [SumW:0] tx;
    logic [SumW:0] ty;
    if (cnt == CntMax) return;
    tx = {1'b0, sx} + (SumW+1)'(x);
    ty = {1'b0, sy} + (SumW+1)'(y);
    cnt = cnt + 1'b1;
    sx = tx[SumW] ? SumMax : tx[SumW-1:0];
    sy = ty[SumW] ? SumMax : ty[SumW-1:0];
  endfunction

  function automatic logic [CoordW-1:0] mean_coord(input logic [SumW-1:0] sum,
                                                   input logic [CntW-1:0] cnt);
    logic [SumW-1:0] q;
    if (cnt == '0) return '0;
    q = sum / cnt;
    return (q > CentLim) ? CentLim : q[CoordW-1:0];
  endfunction

  // Accumulate one pixel; on frame end build the summary and clear the tallies.
  function automatic bit track_pixel(input pix_t p, output res_t summary);
    logic [BoundW-1:0] r;
    logic [BoundW-1:0] g;
    logic [BoundW-1:0] b;
    r = BoundW'(p.pix_red);
    g = BoundW'(p.pix_green);
    b = BoundW'(p.pix_blue);
    summary = '0;
    if (in_span(r, bounds.dark_lower, bounds.dark_upper) &&
        in_span(g, bounds.dark_lower, bounds.dark_upper) &&
        in_span(b, bounds.dark_lower, bounds.dark_upper))
      add_hit(tally.dark_count, tally.dark_sum_x, tally.dark_sum_y, p.col_pos, p.row_pos);
    if (in_span(r, bounds.red_r_lower, bounds.red_r_upper) &&
        in_span(g, bounds.red_g_lower, bounds.red_g_upper) &&
        in_span(b, bounds.red_b_lower, bounds.red_b_upper))
      add_hit(tally.red_count, tally.red_sum_x, tally.red_sum_y, p.col_pos, p.row_pos);
    if (!p.frame_end) return 1'b0;
    summary.dark_hits  = tally.dark_count;
    summary.dark_cx    = mean_coord(tally.dark_sum_x, tally.dark_count);
    summary.dark_cy    = mean_coord(tally.dark_sum_y, tally.dark_count);
    summary.dark_found = (tally.dark_count != '0);
    summary.red_hits   = tally.red_count;
    summary.red_cx     = mean_coord(tally.red_sum_x, tally.red_count);
    summary.red_cy     = mean_coord(tally.red_sum_y, tally.red_count);
    summary.red_found  = (tally.red_count != '0);
    tally = '0;
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (frame_summaries_q.size() == 0) begin
        flag_mismatch("unexpected result, dark_hits", int'(out_data.dark_hits), -1);
      end else begin
        seen_want = frame_summaries_q.pop_front();
        if (out_data.dark_hits != seen_want.dark_hits)
          flag_mismatch("dark_hits", int'(out_data.dark_hits), int'(seen_want.dark_hits));
        if (out_data.dark_cx != seen_want.dark_cx)
          flag_mismatch("dark_cx", int'(out_data.dark_cx), int'(seen_want.dark_cx));
        if (out_data.dark_cy != seen_want.dark_cy)
          flag_mismatch("dark_cy", int'(out_data.dark_cy), int'(seen_want.dark_cy));
        if (out_data.dark_found != seen_want.dark_found)
          flag_mismatch("dark_found", int'(out_data.dark_found), int'(seen_want.dark_found));
        if (out_data.red_hits != seen_want.red_hits)
          flag_mismatch("red_hits", int'(out_data.red_hits), int'(seen_want.red_hits));
        if (out_data.red_cx != seen_want.red_cx)
          flag_mismatch("red_cx", int'(out_data.red_cx), int'(seen_want.red_cx));
        if (out_data.red_cy != seen_want.red_cy)
          flag_mismatch("red_cy", int'(out_data.red_cy), int'(seen_want.red_cy));
        if (out_data.red_found != seen_want.red_found)
          flag_mismatch("red_found", int'(out_data.red_found), int'(seen_want.red_found));
      end
    end
  end

  task automatic send_pix(input pix_t p, input bit typed, input res_t want);
    res_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (track_pixel(p, predicted))
      frame_summaries_q.push_back(typed ? want : predicted);
  endtask

  // Wait until every pending summary has been taken, then idle for the settle period.
  task automatic settle();
    while (frame_summaries_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [BoundW-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
  endtask

  task automatic apply_bounds(input cfg_t c);
    write_reg(RegDarkLower, c.dark_lower);
    write_reg(RegDarkUpper, c.dark_upper);
    write_reg(RegRedRLower, c.red_r_lower);
    write_reg(RegRedRUpper, c.red_r_upper);
    write_reg(RegRedGLower, c.red_g_lower);
    write_reg(RegRedGUpper, c.red_g_upper);
    write_reg(RegRedBLower, c.red_b_lower);
    write_reg(RegRedBUpper, c.red_b_upper);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    bounds = c;
  endtask

  function automatic logic [BoundW-1:0] any_bound();
    if ($urandom_range(99, 0) < 85) return BoundW'($urandom_range(32, 0));
    return BoundW'($urandom_range(63, 33));
  endfunction

  function automatic cfg_t pick_setting(input int k);
    cfg_t c;
    case (k)
      1: c = '{6'd0, 6'd32, 6'd0, 6'd32, 6'd0, 6'd32, 6'd0, 6'd32};
      // empty and out-of-range intervals: nothing ever matches
      2: c = '{6'd63, 6'd63, 6'd32, 6'd0, 6'd31, 6'd31, 6'd62, 6'd1};
      4: c = '{any_bound(), any_bound(), any_bound(), any_bound(),
               any_bound(), any_bound(), any_bound(), any_bound()};
      5: c = RstBounds;
      default: begin
        c.dark_lower  = BoundW'($urandom_range(10, 0));
        c.dark_upper  = c.dark_lower + BoundW'($urandom_range(14, 2));
        c.red_r_lower = BoundW'($urandom_range(28, 14));
        c.red_r_upper = BoundW'($urandom_range(32, c.red_r_lower + 2));
        c.red_g_lower = BoundW'($urandom_range(10, 0));
        c.red_g_upper = c.red_g_lower + BoundW'($urandom_range(14, 2));
        c.red_b_lower = BoundW'($urandom_range(10, 0));
        c.red_b_upper = c.red_b_lower + BoundW'($urandom_range(14, 2));
      end
    endcase
    return c;
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] pick_in(input logic [BoundW-1:0] lo,
                                                      input logic [BoundW-1:0] hi);
    int a;
    int b;
    a = int'(lo) + 1;
    b = int'(hi) - 1;
    if (b > 31) b = 31;
    if (a > b) return CHANNEL_BITS'($urandom_range(31, 0));
    return CHANNEL_BITS'($urandom_range(b, a));
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] pick_edge(input logic [BoundW-1:0] lo,
                                                        input logic [BoundW-1:0] hi);
    return $urandom_range(1, 0) ? lo[CHANNEL_BITS-1:0] : hi[CHANNEL_BITS-1:0];
  endfunction

  function automatic pix_t rand_pixel(input bit last);
    pix_t p;
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 40) begin
      p.pix_red   = pick_in(bounds.dark_lower, bounds.dark_upper);
      p.pix_green = pick_in(bounds.dark_lower, bounds.dark_upper);
      p.pix_blue  = pick_in(bounds.dark_lower, bounds.dark_upper);
    end else if (sel < 70) begin
      p.pix_red   = pick_in(bounds.red_r_lower, bounds.red_r_upper);
      p.pix_green = pick_in(bounds.red_g_lower, bounds.red_g_upper);
      p.pix_blue  = pick_in(bounds.red_b_lower, bounds.red_b_upper);
    end else if (sel < 80) begin
      // sit on the exclusive bounds
      p.pix_red   = pick_edge(bounds.red_r_lower, bounds.red_r_upper);
      p.pix_green = pick_edge(bounds.dark_lower, bounds.dark_upper);
      p.pix_blue  = pick_edge(bounds.red_b_lower, bounds.dark_upper);
    end else begin
      p.pix_red   = CHANNEL_BITS'($urandom_range(31, 0));
      p.pix_green = CHANNEL_BITS'($urandom_range(31, 0));
      p.pix_blue  = CHANNEL_BITS'($urandom_range(31, 0));
    end
    p.col_pos   = CoordW'($urandom_range(127, 0));
    p.row_pos   = CoordW'($urandom_range(127, 0));
    p.frame_end = last;
    return p;
  endfunction

  function automatic pix_row_t mk_row(input int r, input int g, input int b, input int x,
                                      input int y, input bit fe, input int reps);
    pix_row_t row;
    row.pix   = '{pix_red: CHANNEL_BITS'(r), pix_green: CHANNEL_BITS'(g),
                  pix_blue: CHANNEL_BITS'(b), col_pos: CoordW'(x), row_pos: CoordW'(y),
                  frame_end: fe};
    row.reps  = reps;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  initial begin
    pix_row_t rows[$];
    pix_row_t row;
    int n;
    int len;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty boxes
    row = mk_row(0, 0, 0, 0, 0, 1'b1, 1);
    row.typed = 1'b1;
    rows.push_back(row);
    // single dark hit at the far corner
    row = mk_row(1, 1, 1, 127, 127, 1'b1, 1);
    row.typed = 1'b1;
    row.want.dark_hits = 15'd1; row.want.dark_cx = 7'd127;
    row.want.dark_cy = 7'd127; row.want.dark_found = 1'b1;
    rows.push_back(row);
    // single red hit
    row = mk_row(31, 1, 1, 0, 127, 1'b1, 1);
    row.typed = 1'b1;
    row.want.red_hits = 15'd1; row.want.red_cx = 7'd0;
    row.want.red_cy = 7'd127; row.want.red_found = 1'b1;
    rows.push_back(row);
    rows.push_back(mk_row(31, 31, 31, 127, 127, 1'b0, 1));
    rows.push_back(mk_row(3, 3, 3, 0, 0, 1'b0, 1));
    rows.push_back(mk_row(29, 3, 3, 64, 32, 1'b0, 1));
    rows.push_back(mk_row(28, 2, 2, 10, 20, 1'b0, 1));
    rows.push_back(mk_row(4, 1, 1, 30, 40, 1'b0, 1));
    rows.push_back(mk_row(2, 2, 2, 5, 9, 1'b1, 1));
    rows.push_back(mk_row(21, 10, 5, 85, 42, 1'b0, 1));
    rows.push_back(mk_row(10, 21, 26, 42, 85, 1'b1, 1));
    // overlong frame: the count stops and the sums saturate
    rows.push_back(mk_row(1, 1, 1, 127, 127, 1'b0, LongFrame));
    row = mk_row(30, 2, 3, 127, 127, 1'b1, 1);
    row.typed = 1'b1;
    row.want.dark_hits = CntMax; row.want.dark_cx = 7'd64;
    row.want.dark_cy = 7'd64; row.want.dark_found = 1'b1;
    row.want.red_hits = 15'd1; row.want.red_cx = 7'd127;
    row.want.red_cy = 7'd127; row.want.red_found = 1'b1;
    rows.push_back(row);
    // tallies cleared after saturation
    row = mk_row(0, 0, 0, 0, 0, 1'b1, 1);
    row.typed = 1'b1;
    rows.push_back(row);

    send_idle_pct = 10;
    recv_idle_pct = 64;
    foreach (rows[i]) begin
      for (int k = 0; k < rows[i].reps; k++)
        send_pix(rows[i].pix, rows[i].typed, rows[i].want);
    end

    for (int k = 0; k < 6; k++) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      settle();
      if (k < 2) begin
        send_idle_pct = 10;
        recv_idle_pct = 64;
      end else if (k < 4) begin
        send_idle_pct = 64;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_bounds(pick_setting(k));
      n = 0;
      while (n < ItemsPerSetting) begin
        len = ($urandom_range(99, 0) < 70) ? $urandom_range(12, 1) : $urandom_range(60, 13);
        for (int i = 0; i < len; i++)
          send_pix(rand_pixel(i == len - 1), 1'b0, '0);
        n += len;
      end
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    settle();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/cbc_pkg.sv
hw/rtl/cbc_accum.sv
hw/rtl/cbc_div.sv
hw/rtl/color_box_centroid_tracker.sv
tb/sv/color_box_centroid_tracker_tb.sv
